### rtl/core/tvcd_pkg.sv
// Shared types and constants for the two-valve collect/drain sequencer.
// Holds the phase encoding, register indexes, reset values and the state,
// switch, configuration and result structs. No dependencies.
`timescale 1ns / 1ps

package tvcd_pkg;

    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned LED_W      = 4;
    localparam int unsigned PHASE_W    = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] VALVE_TIMEOUT_RESET = 16'd2000;
    localparam logic [CNT_W-1:0] DRAIN_RESET         = 16'd2000;
    localparam logic [CNT_W-1:0] BLINK_HALF_RESET    = 16'd200;

    // LED codes: bit0 open top, bit1 close top, bit2 open bottom, bit3 close bottom.
    localparam logic [LED_W-1:0] LED_NONE         = 4'h0;
    localparam logic [LED_W-1:0] LED_OPEN_TOP     = 4'h1;
    localparam logic [LED_W-1:0] LED_CLOSE_TOP    = 4'h2;
    localparam logic [LED_W-1:0] LED_OPEN_BOTTOM  = 4'h4;
    localparam logic [LED_W-1:0] LED_CLOSE_BOTTOM = 4'h8;
    localparam logic [LED_W-1:0] LED_ALL          = 4'hF;

    // Direction pin pairs as {dir_two, dir_one}.
    localparam logic [1:0] DIR_OPEN  = 2'b01;
    localparam logic [1:0] DIR_CLOSE = 2'b10;

    typedef enum logic [PHASE_W-1:0] {
        PH_CLOSE_BOTTOM = 3'd0,
        PH_OPEN_TOP     = 3'd1,
        PH_WAIT_SHOCK   = 3'd2,
        PH_CLOSE_TOP    = 3'd3,
        PH_OPEN_BOTTOM  = 3'd4,
        PH_DRAIN        = 3'd5,
        PH_FAULT        = 3'd6
    } phase_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_VALVE_TIMEOUT = 2'd0,
        CFG_DRAIN         = 2'd1,
        CFG_BLINK_HALF    = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        logic [CNT_W-1:0] valve_timeout_ticks;
        logic [CNT_W-1:0] drain_ticks;
        logic [CNT_W-1:0] blink_half_ticks;
    } cfg_t;

    typedef struct packed {
        logic upper_open;
        logic upper_shut;
        logic lower_open;
        logic lower_shut;
        logic shock;
    } switches_t;

    // dir bits: [0] top one, [1] top two, [2] bottom one, [3] bottom two.
    typedef struct packed {
        phase_t           phase;
        logic [CNT_W-1:0] elapsed;
        logic             blink_level;
        logic             message_bit;
        logic [3:0]       dir;
    } state_t;

    typedef struct packed {
        logic             top_dir_one;
        logic             top_dir_two;
        logic             top_drive_enable;
        logic             bottom_dir_one;
        logic             bottom_dir_two;
        logic             bottom_drive_enable;
        logic [LED_W-1:0] led_pattern;
        logic             message_select;
        logic             fault_active;
        logic [PHASE_W-1:0] phase_code;
    } result_t;

endpackage

### rtl/core/tvcd_if.sv
// Channel interfaces for the sequencer: tick input, result output and
// configuration write. Each carries valid, ready and its payload.
// Depends on tvcd_pkg for field widths.
`timescale 1ns / 1ps

interface tvcd_tick_if;
    logic valid;
    logic ready;
    logic top_open_switch;
    logic top_closed_switch;
    logic bottom_open_switch;
    logic bottom_closed_switch;
    logic shock_detected;

    modport source (
        output valid, top_open_switch, top_closed_switch,
               bottom_open_switch, bottom_closed_switch, shock_detected,
        input  ready
    );
    modport sink (
        input  valid, top_open_switch, top_closed_switch,
               bottom_open_switch, bottom_closed_switch, shock_detected,
        output ready
    );
endinterface

interface tvcd_result_if;
    logic valid;
    logic ready;
    logic top_dir_one;
    logic top_dir_two;
    logic top_drive_enable;
    logic bottom_dir_one;
    logic bottom_dir_two;
    logic bottom_drive_enable;
    logic [tvcd_pkg::LED_W-1:0]   led_pattern;
    logic message_select;
    logic fault_active;
    logic [tvcd_pkg::PHASE_W-1:0] phase_code;

    modport source (
        output valid, top_dir_one, top_dir_two, top_drive_enable,
               bottom_dir_one, bottom_dir_two, bottom_drive_enable,
               led_pattern, message_select, fault_active, phase_code,
        input  ready
    );
    modport sink (
        input  valid, top_dir_one, top_dir_two, top_drive_enable,
               bottom_dir_one, bottom_dir_two, bottom_drive_enable,
               led_pattern, message_select, fault_active, phase_code,
        output ready
    );
endinterface

interface tvcd_cfg_if;
    logic valid;
    logic ready;
    logic [tvcd_pkg::CFG_ADDR_W-1:0] addr;
    logic [tvcd_pkg::CNT_W-1:0]      data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/core/tvcd_cfg_regs.sv
// Configuration register file: valve timeout, drain time and blink half period.
// Takes one write beat per cycle; writes to unused indexes are dropped.
// Depends on tvcd_pkg and tvcd_cfg_if.
`timescale 1ns / 1ps

module tvcd_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    tvcd_cfg_if.sink       cfg,
    output tvcd_pkg::cfg_t regs
);
    import tvcd_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_VALVE_TIMEOUT: regs_next.valve_timeout_ticks = cfg.data;
                CFG_DRAIN:         regs_next.drain_ticks         = cfg.data;
                CFG_BLINK_HALF:    regs_next.blink_half_ticks    = cfg.data;
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.valve_timeout_ticks <= VALVE_TIMEOUT_RESET;
            regs_reg.drain_ticks         <= DRAIN_RESET;
            regs_reg.blink_half_ticks    <= BLINK_HALF_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

### rtl/core/tvcd_step.sv
// Per-tick sequencing logic: from the current state, switch samples and
// registers it forms the next state and the result of the tick.
// Purely combinational. Depends on tvcd_pkg.
`timescale 1ns / 1ps

module tvcd_step (
    input  tvcd_pkg::state_t    st,
    input  tvcd_pkg::switches_t sw,
    input  tvcd_pkg::cfg_t      regs,
    output tvcd_pkg::state_t    nxt,
    output tvcd_pkg::result_t   res
);
    import tvcd_pkg::*;

    logic [CNT_W-1:0] bumped;
    logic             valve_phase;
    logic             reached;
    phase_t           after_valve;
    logic             en_top;
    logic             en_bot;
    logic             fault;
    logic [LED_W-1:0] leds;

    // The elapsed count saturates rather than wrapping.
    assign bumped = (st.elapsed == CNT_MAX) ? st.elapsed : st.elapsed + 1'b1;

    always_comb
    begin
        nxt         = st;
        valve_phase = 1'b0;
        reached     = 1'b0;
        after_valve = PH_FAULT;
        en_top      = 1'b0;
        en_bot      = 1'b0;
        fault       = 1'b0;
        leds        = LED_NONE;

        case (st.phase)
            PH_CLOSE_BOTTOM:
            begin
                nxt.dir[3:2] = DIR_CLOSE;
                en_bot       = 1'b1;
                leds         = LED_CLOSE_BOTTOM;
                reached      = sw.lower_shut;
                after_valve  = PH_OPEN_TOP;
                valve_phase  = 1'b1;
            end
            PH_OPEN_TOP:
            begin
                nxt.dir[1:0] = DIR_OPEN;
                en_top       = 1'b1;
                leds         = LED_OPEN_TOP;
                reached      = sw.upper_open;
                after_valve  = PH_WAIT_SHOCK;
                valve_phase  = 1'b1;
            end
            PH_CLOSE_TOP:
            begin
                nxt.dir[1:0] = DIR_CLOSE;
                en_top       = 1'b1;
                leds         = LED_CLOSE_TOP;
                reached      = sw.upper_shut;
                after_valve  = PH_OPEN_BOTTOM;
                valve_phase  = 1'b1;
            end
            PH_OPEN_BOTTOM:
            begin
                nxt.dir[3:2] = DIR_OPEN;
                en_bot       = 1'b1;
                leds         = LED_OPEN_BOTTOM;
                reached      = sw.lower_open;
                after_valve  = PH_DRAIN;
                valve_phase  = 1'b1;
            end
            PH_WAIT_SHOCK:
            begin
                leds = LED_ALL;
                if (sw.shock)
                begin
                    nxt.message_bit = ~st.message_bit;
                    nxt.phase       = PH_CLOSE_TOP;
                    nxt.elapsed     = '0;
                end
            end
            PH_DRAIN:
            begin
                leds        = LED_NONE;
                nxt.elapsed = bumped;
                if (bumped >= regs.drain_ticks)
                begin
                    nxt.phase   = PH_CLOSE_BOTTOM;
                    nxt.elapsed = '0;
                end
            end
            default:
            begin
                // Fault, and the unused phase code, which behaves the same.
                fault       = 1'b1;
                leds        = st.blink_level ? LED_NONE : LED_ALL;
                nxt.elapsed = bumped;
                if (bumped >= regs.blink_half_ticks)
                begin
                    nxt.blink_level = ~st.blink_level;
                    nxt.elapsed     = '0;
                end
            end
        endcase

        if (valve_phase)
        begin
            if (reached)
            begin
                nxt.phase   = after_valve;
                nxt.elapsed = '0;
            end
            else if (bumped >= regs.valve_timeout_ticks)
            begin
                nxt.phase       = PH_FAULT;
                nxt.elapsed     = '0;
                nxt.blink_level = 1'b0;
            end
            else
            begin
                nxt.elapsed = bumped;
            end
        end
    end

    always_comb
    begin
        res.top_dir_one         = nxt.dir[0];
        res.top_dir_two         = nxt.dir[1];
        res.top_drive_enable    = en_top;
        res.bottom_dir_one      = nxt.dir[2];
        res.bottom_dir_two      = nxt.dir[3];
        res.bottom_drive_enable = en_bot;
        res.led_pattern         = leds;
        res.message_select      = st.message_bit;
        res.fault_active        = fault;
        res.phase_code          = st.phase;
    end

endmodule

### rtl/core/two_valve_collect_drain_sequencer.sv
// Top level of the two-valve collect/drain sequencer.
// Holds the sequencer state and the result register; instantiates
// tvcd_cfg_regs and tvcd_step. Depends on tvcd_pkg and the tvcd interfaces.
`timescale 1ns / 1ps

// Each tick beat carries one millisecond of limit switch and shock samples
// and yields exactly one result beat, in the next cycle, from a registered
// output stage. A tick is taken in every clock cycle as long as the result
// register is empty or is being drained in the same cycle, so the block
// sustains one tick per cycle; that figure is set by the phase, counter and
// latch update, which is combinational through the step logic.
// Register writes take effect on the next tick and are accepted every cycle.
// After reset the sequence starts with closing the bottom valve. A valve that
// misses its limit switch within the timeout leaves the block in fault, with
// all LEDs blinking, until the next reset.
module two_valve_collect_drain_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    tvcd_tick_if.sink   tick,
    tvcd_result_if.source result,
    tvcd_cfg_if.sink    cfg
);
    import tvcd_pkg::*;

    cfg_t      regs;
    switches_t sw;
    state_t    state_reg;
    state_t    state_next;
    result_t   res_reg;
    result_t   res_next;
    logic      out_valid_reg;
    logic      tick_fire;

    tvcd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    assign sw.upper_open = tick.top_open_switch;
    assign sw.upper_shut = tick.top_closed_switch;
    assign sw.lower_open = tick.bottom_open_switch;
    assign sw.lower_shut = tick.bottom_closed_switch;
    assign sw.shock      = tick.shock_detected;

    tvcd_step u_step (
        .st   (state_reg),
        .sw   (sw),
        .regs (regs),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign tick.ready = !out_valid_reg || result.ready;
    assign tick_fire  = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_CLOSE_BOTTOM;
            state_reg.elapsed     <= '0;
            state_reg.blink_level <= 1'b0;
            state_reg.message_bit <= 1'b0;
            state_reg.dir         <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (tick_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.top_dir_one         = res_reg.top_dir_one;
    assign result.top_dir_two         = res_reg.top_dir_two;
    assign result.top_drive_enable    = res_reg.top_drive_enable;
    assign result.bottom_dir_one      = res_reg.bottom_dir_one;
    assign result.bottom_dir_two      = res_reg.bottom_dir_two;
    assign result.bottom_drive_enable = res_reg.bottom_drive_enable;
    assign result.led_pattern         = res_reg.led_pattern;
    assign result.message_select      = res_reg.message_select;
    assign result.fault_active        = res_reg.fault_active;
    assign result.phase_code          = res_reg.phase_code;

    // Only reset leaves the fault phase.
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_FAULT |=> state_reg.phase == PH_FAULT)
        else $error("sequencer left the fault phase");

    // Every accepted tick leaves a result waiting in the next cycle.
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> out_valid_reg)
        else $error("accepted tick produced no result");

    // The two bridges are never enabled in the same tick.
    a_bridges_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.top_drive_enable && res_reg.bottom_drive_enable))
        else $error("both valve bridges enabled");

    // In fault all LEDs are on or all are off.
    a_fault_leds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.fault_active)
        |-> (res_reg.led_pattern == LED_ALL || res_reg.led_pattern == LED_NONE))
        else $error("fault LED pattern is not all on or all off");

    // The message bit changes only on a shock while waiting for one.
    a_message_on_shock: assert property (@(posedge clk) disable iff (!rst_n)
        !(tick_fire && state_reg.phase == PH_WAIT_SHOCK && tick.shock_detected)
        |=> $stable(state_reg.message_bit))
        else $error("message bit changed without a shock");

endmodule
